// ===== rtl/circuit_depth_layering_top_assert.svh =====
`ifndef CIRCUIT_DEPTH_LAYERING_TOP_ASSERT_SVH
`define CIRCUIT_DEPTH_LAYERING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CDL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circuit_depth_layering: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CDL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circuit_depth_layering: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define CDL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("circuit_depth_layering: reset check failed");

`endif

// ===== rtl/cdl_pkg.sv =====
package cdl_pkg;

  localparam int QUBITS_DEF     = 128;
  localparam int LAYER_BITS_DEF = 24;

  // item kinds
  localparam logic [1:0] KIND_GATE = 2'd0;
  localparam logic [1:0] KIND_LINK = 2'd1;
  localparam logic [1:0] KIND_NEW  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_QUBITS_IN_USE = 2'd0;
  localparam logic [1:0] CFG_CONN_CHECK    = 2'd1;
  localparam logic [1:0] CFG_SWAP_PENALTY  = 2'd2;

  localparam logic [7:0] QUBITS_IN_USE_RST = 8'd128;
  localparam logic       CONN_CHECK_RST    = 1'b0;
  localparam logic [7:0] SWAP_PENALTY_RST  = 8'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic       gate_is_cz;
    logic [6:0] target;
    logic [6:0] control;
    logic       link_present;
  } in_word_t;

  typedef struct packed {
    logic [23:0] gate_layer;
    logic [23:0] circuit_depth;
    logic        index_error;
  } out_word_t;

endpackage

// ===== rtl/cdl_ram.sv =====
module cdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/circuit_depth_layering_top.sv =====
// ASAP circuit levelizer. Each input word is a gate, a connectivity-matrix
// write or a new-circuit marker, and gives exactly one output word carrying
// the gate's layer, the running circuit depth and an index error flag. The
// block takes one word per clock cycle while the input is not stalled; the
// word is registered into the update stage, and its result is loaded into
// the output register when that stage advances. The synchronous read of
// the layer and connectivity memories is issued as the word is taken and
// completes in the update stage, which computes the new layer. That rate is
// set by the read-modify-write of the per-qubit layer memories: the word in
// the update stage writes its new layer back while the next word's read is
// under way, and the written value is forwarded to that next word. Output
// back-pressure stops the update stage, and the input stalls only when both
// the update stage and the output register are full. The new-circuit marker
// clears the layers at once through per-qubit valid bits; no clearing pass
// runs after reset. The connectivity matrix is not cleared: a link that is
// read before it has been written may read as anything.
module circuit_depth_layering_top #(
  parameter int QUBITS     = cdl_pkg::QUBITS_DEF,
  parameter int LAYER_BITS = cdl_pkg::LAYER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cdl_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cdl_pkg::out_word_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  import cdl_pkg::*;

  localparam int QB = $clog2(QUBITS);
  localparam int CA = $clog2(QUBITS * QUBITS);
  localparam int LB = LAYER_BITS;

  // configuration registers
  logic [7:0] qubits_in_use;
  logic       conn_check;
  logic [7:0] swap_penalty;

  // pipeline control
  logic     s1_valid;
  in_word_t s1;
  logic     accept;
  logic     advance;

  // per-qubit flags: valid clears on a new circuit, bank_sel picks the
  // bank that holds the newest layer (0 target bank, 1 control bank)
  logic [QUBITS-1:0] layer_valid;
  logic [QUBITS-1:0] bank_sel;

  // forwarding of the last retired word's writes
  logic          fw_t_en;
  logic          fw_c_en;
  logic [QB-1:0] fw_t_q;
  logic [QB-1:0] fw_c_q;
  logic [LB-1:0] fw_val;
  logic          cw_en;
  logic [CA-1:0] cw_addr;
  logic          cw_bit;

  logic [LB-1:0] depth_peak;

  // memory read data
  logic [LB-1:0] a_t_rd, a_c_rd, b_t_rd, b_c_rd;
  logic          conn_rd;

  // update stage signals
  logic [QB-1:0] in_t_q, in_c_q, t_q, c_q;
  logic [CA-1:0] in_caddr, s1_caddr;
  logic          is_gate, is_link, is_new, cz;
  logic          t_bad, c_bad, err, gate_ok, link_ok;
  logic [LB-1:0] lt, lc, lmax, layer_new, depth_peak_next;
  logic          link_bit;
  logic [7:0]    pen;
  logic [LB:0]   sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qubits_in_use <= QUBITS_IN_USE_RST;
      conn_check    <= CONN_CHECK_RST;
      swap_penalty  <= SWAP_PENALTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUBITS_IN_USE: qubits_in_use <= cfg_data;
        CFG_CONN_CHECK:    conn_check    <= cfg_data[0];
        CFG_SWAP_PENALTY:  swap_penalty  <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Advance the update stage when the output register is free or emptying;
  // stall the input only while the update stage holds a word it cannot pass.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_data;
    end
  end

  // Memory addresses: reads are issued from the input word as it is taken.
  assign in_t_q   = QB'(in_data.target);
  assign in_c_q   = QB'(in_data.control);
  assign in_caddr = CA'(in_c_q) * CA'(QUBITS) + CA'(in_t_q);
  assign t_q      = QB'(s1.target);
  assign c_q      = QB'(s1.control);
  assign s1_caddr = CA'(c_q) * CA'(QUBITS) + CA'(t_q);

  // Index checks: the limit is the smaller of qubits_in_use and QUBITS.
  assign t_bad = (8'(s1.target) >= qubits_in_use) || (32'(s1.target) >= QUBITS);
  assign c_bad = (8'(s1.control) >= qubits_in_use) || (32'(s1.control) >= QUBITS);

  assign is_gate = (s1.kind == KIND_GATE);
  assign is_link = (s1.kind == KIND_LINK);
  assign is_new  = (s1.kind == KIND_NEW);
  assign cz      = s1.gate_is_cz;

  always_comb begin
    err = 1'b0;
    if (is_gate) begin
      err = t_bad || (cz && c_bad);
    end else if (is_link) begin
      err = t_bad || c_bad;
    end
  end

  assign gate_ok = is_gate && !err;
  assign link_ok = is_link && !err;

  // Current layers: forwarded word first, then the newest bank, then zero
  // for a qubit untouched since the circuit started.
  always_comb begin
    if ((fw_t_en && fw_t_q == t_q) || (fw_c_en && fw_c_q == t_q)) begin
      lt = fw_val;
    end else if (layer_valid[t_q]) begin
      lt = bank_sel[t_q] ? b_t_rd : a_t_rd;
    end else begin
      lt = '0;
    end
    if ((fw_t_en && fw_t_q == c_q) || (fw_c_en && fw_c_q == c_q)) begin
      lc = fw_val;
    end else if (layer_valid[c_q]) begin
      lc = bank_sel[c_q] ? b_c_rd : a_c_rd;
    end else begin
      lc = '0;
    end
  end

  assign link_bit = (cw_en && cw_addr == s1_caddr) ? cw_bit : conn_rd;
  assign lmax     = (cz && lc > lt) ? lc : lt;
  assign pen      = (cz && conn_check && !link_bit) ? swap_penalty : 8'd0;

  // Penalty and increment in one add; saturation folds into the carry out.
  assign sum       = {1'b0, lmax} + (LB+1)'(pen) + (LB+1)'(1);
  assign layer_new = sum[LB] ? {LB{1'b1}} : sum[LB-1:0];

  always_comb begin
    if (is_new) begin
      depth_peak_next = '0;
    end else if (gate_ok && layer_new > depth_peak) begin
      depth_peak_next = layer_new;
    end else begin
      depth_peak_next = depth_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_peak  <= '0;
      layer_valid <= '0;
      fw_t_en     <= 1'b0;
      fw_c_en     <= 1'b0;
      cw_en       <= 1'b0;
    end else if (advance) begin
      depth_peak <= depth_peak_next;
      if (is_new) begin
        layer_valid <= '0;
      end else if (gate_ok) begin
        layer_valid[t_q] <= 1'b1;
        if (cz) begin
          layer_valid[c_q] <= 1'b1;
        end
      end
      fw_t_en <= gate_ok;
      fw_c_en <= gate_ok && cz;
      cw_en   <= link_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fw_t_q  <= t_q;
      fw_c_q  <= c_q;
      fw_val  <= layer_new;
      cw_addr <= s1_caddr;
      cw_bit  <= s1.link_present;
      if (gate_ok) begin
        bank_sel[t_q] <= 1'b0;
        if (cz) begin
          bank_sel[c_q] <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.gate_layer    <= gate_ok ? 24'(layer_new) : 24'd0;
      out_data.circuit_depth <= 24'(depth_peak_next);
      out_data.index_error   <= err;
    end
  end

  // Target bank: written at the target qubit, read at both qubits.
  cdl_ram #(.WIDTH(LB), .DEPTH(QUBITS)) u_bank_a_t (
    .clk     (clk),
    .wr_en   (advance && gate_ok),
    .wr_addr (t_q),
    .wr_data (layer_new),
    .rd_en   (accept),
    .rd_addr (in_t_q),
    .rd_data (a_t_rd)
  );

  cdl_ram #(.WIDTH(LB), .DEPTH(QUBITS)) u_bank_a_c (
    .clk     (clk),
    .wr_en   (advance && gate_ok),
    .wr_addr (t_q),
    .wr_data (layer_new),
    .rd_en   (accept),
    .rd_addr (in_c_q),
    .rd_data (a_c_rd)
  );

  // Control bank: written at the control qubit of a CZ.
  cdl_ram #(.WIDTH(LB), .DEPTH(QUBITS)) u_bank_b_t (
    .clk     (clk),
    .wr_en   (advance && gate_ok && cz),
    .wr_addr (c_q),
    .wr_data (layer_new),
    .rd_en   (accept),
    .rd_addr (in_t_q),
    .rd_data (b_t_rd)
  );

  cdl_ram #(.WIDTH(LB), .DEPTH(QUBITS)) u_bank_b_c (
    .clk     (clk),
    .wr_en   (advance && gate_ok && cz),
    .wr_addr (c_q),
    .wr_data (layer_new),
    .rd_en   (accept),
    .rd_addr (in_c_q),
    .rd_data (b_c_rd)
  );

  // Connectivity matrix, row control, column target.
  cdl_ram #(.WIDTH(1), .DEPTH(QUBITS * QUBITS)) u_conn (
    .clk     (clk),
    .wr_en   (advance && link_ok),
    .wr_addr (s1_caddr),
    .wr_data (s1.link_present),
    .rd_en   (accept),
    .rd_addr (in_caddr),
    .rd_data (conn_rd)
  );

endmodule

// ===== rtl/cdl_checker.sv =====
`include "circuit_depth_layering_top_assert.svh"

module cdl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cdl_pkg::out_word_t out_data
);

  // a stalled output word holds
  `CDL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(out_data))

  // a flagged word never carries a layer
  `CDL_ASSERT_NOW(a_err_no_layer, clk, rst, out_valid && out_data.index_error,
                  out_data.gate_layer == 24'd0)

  // input stalls only behind a full, stalled output register
  `CDL_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // reset empties the pipeline
  `CDL_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)

endmodule

bind circuit_depth_layering_top cdl_checker u_cdl_checker (.*);

// ===== tb/depth_tracker_pkg.sv =====
package depth_tracker_pkg;
  import cdl_pkg::*;

  localparam int QUBITS = cdl_pkg::QUBITS_DEF;
  localparam int LB     = cdl_pkg::LAYER_BITS_DEF;

  // Kind with no meaning to the block: it must pass through untouched.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef logic [LB-1:0] layer_t;

  // Tracks per-qubit layers, links and depth, and queues the result word
  // that each accepted input word should produce.
  class depth_tracker;
    logic [7:0] qubits_in_use;
    logic       check_on;
    logic [7:0] penalty;
    layer_t     layer_of   [QUBITS];
    bit         layer_live [QUBITS];
    bit         link_bit   [QUBITS*QUBITS];
    bit         link_known [QUBITS*QUBITS];
    layer_t     depth;
    out_word_t  expected_words [$];
    int         failures;

    function new();
      qubits_in_use = QUBITS_IN_USE_RST;
      check_on      = CONN_CHECK_RST;
      penalty       = SWAP_PENALTY_RST;
      foreach (layer_live[q]) layer_live[q] = 1'b0;
      foreach (link_known[i]) link_known[i] = 1'b0;
      depth    = '0;
      failures = 0;
    endfunction

    function int unsigned limit();
      return (qubits_in_use < QUBITS) ? qubits_in_use : QUBITS;
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_QUBITS_IN_USE: qubits_in_use = data;
        CFG_CONN_CHECK:    check_on = data[0];
        CFG_SWAP_PENALTY:  penalty = data;
        default: ;
      endcase
    endfunction

    function layer_t sat_add(layer_t a, layer_t b);
      logic [LB:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[LB] ? '1 : sum[LB-1:0];
    endfunction

    function layer_t layer_at(logic [6:0] q);
      return layer_live[q] ? layer_of[q] : '0;
    endfunction

    function void note_word(in_word_t w);
      int unsigned lim;
      int          link_idx;
      layer_t      lay;
      out_word_t   res;
      lim      = limit();
      link_idx = int'(w.control) * QUBITS + int'(w.target);
      res      = '0;
      case (w.kind)
        KIND_GATE: begin
          if (w.target >= lim || (w.gate_is_cz && w.control >= lim)) begin
            res.index_error = 1'b1;
          end else begin
            lay = layer_at(w.target);
            if (w.gate_is_cz) begin
              if (layer_at(w.control) > lay) lay = layer_at(w.control);
              if (check_on && !link_bit[link_idx]) lay = sat_add(lay, layer_t'(penalty));
            end
            lay = sat_add(lay, layer_t'(1));
            layer_of[w.target]   = lay;
            layer_live[w.target] = 1'b1;
            if (w.gate_is_cz) begin
              layer_of[w.control]   = lay;
              layer_live[w.control] = 1'b1;
            end
            if (lay > depth) depth = lay;
            res.gate_layer = lay;
          end
        end
        KIND_LINK: begin
          if (w.target >= lim || w.control >= lim) begin
            res.index_error = 1'b1;
          end else begin
            link_bit[link_idx]   = w.link_present;
            link_known[link_idx] = 1'b1;
          end
        end
        KIND_NEW: begin
          foreach (layer_live[q]) layer_live[q] = 1'b0;
          depth = '0;
        end
        default: ;
      endcase
      res.circuit_depth = depth;
      expected_words.push_back(res);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: gate_layer %0d circuit_depth %0d",
               got.gate_layer, got.circuit_depth);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (got.gate_layer !== want.gate_layer) begin
        $error("gate_layer: expected %0d, got %0d", want.gate_layer, got.gate_layer);
        failures++;
      end
      if (got.circuit_depth !== want.circuit_depth) begin
        $error("circuit_depth: expected %0d, got %0d", want.circuit_depth, got.circuit_depth);
        failures++;
      end
      if (got.index_error !== want.index_error) begin
        $error("index_error: expected %0d, got %0d", want.index_error, got.index_error);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdl_pkg::*;
  import depth_tracker_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = CFG_QUBITS_IN_USE;
  logic [7:0] cfg_data = '0;

  depth_tracker tracker;

  // Idle rates in percent.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  // Long receiver hold-off: raised by the stimulus, counted down by the receiver.
  bit          hold_request      = 1'b0;
  int unsigned hold_left         = 0;
  int unsigned cycle_count       = 0;

  circuit_depth_layering_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a run that has not finished by now has hung.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check each word taken, then choose next cycle's stall.
  // A hold-off request wins over the random stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_word(out_data);
    if (hold_request) begin
      hold_left    = 80;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic cz, logic [6:0] tgt,
                                         logic [6:0] ctl, logic link);
    in_word_t w;
    w.kind         = kind;
    w.gate_is_cz   = cz;
    w.target       = tgt;
    w.control      = ctl;
    w.link_present = link;
    return w;
  endfunction

  // Favour a handful of low qubits so that layers stack up, but reach the
  // whole range in use and, now and then, indices beyond it.
  function automatic logic [6:0] pick_qubit();
    int unsigned lim;
    int unsigned hot;
    int unsigned r;
    lim = tracker.limit();
    hot = (lim < 8) ? lim : 8;
    r   = $urandom_range(0, 99);
    if (lim > 0 && r < 60) return 7'($urandom_range(0, hot - 1));
    if (lim > 0 && r < 88) return 7'($urandom_range(0, lim - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.gate_is_cz   = 1'($urandom_range(0, 1));
    w.link_present = 1'($urandom_range(0, 1));
    w.target       = pick_qubit();
    w.control      = pick_qubit();
    if (r < 75)      w.kind = KIND_GATE;
    else if (r < 90) w.kind = KIND_LINK;
    else if (r < 95) w.kind = KIND_NEW;
    else             w.kind = KIND_UNUSED;
    return w;
  endfunction

  // Offer one input word and hold it until taken; note it on acceptance.
  // Each cycle before the offer idles at the sender's rate.
  // Valid is lowered only for a gap, so it never drops and rises in one step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
  endtask

  // A CZ that would consult a link never written gets that link written
  // first, with a random value, so the lookup is always defined.
  task automatic send_random();
    in_word_t w;
    in_word_t pre;
    w = random_word();
    if (w.kind == KIND_GATE && w.gate_is_cz && tracker.check_on &&
        w.target < tracker.limit() && w.control < tracker.limit() &&
        !tracker.link_known[int'(w.control) * QUBITS + int'(w.target)]) begin
      pre              = w;
      pre.kind         = KIND_LINK;
      pre.link_present = 1'($urandom_range(0, 1));
      send_word(pre);
    end
    send_word(w);
  endtask

  // Drop valid and wait until every word sent has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, val);
  endtask

  task automatic configure(input logic [7:0] qubits, input logic check,
                           input logic [7:0] penalty);
    write_register(CFG_QUBITS_IN_USE, qubits);
    write_register(CFG_CONN_CHECK, {7'd0, check});
    write_register(CFG_SWAP_PENALTY, penalty);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_settings();
    logic [7:0]  qubits;
    logic [7:0]  penalty;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: qubits = 8'd1;
      1: qubits = 8'd2;
      2: qubits = 8'd3;
      3: qubits = 8'd8;
      4: qubits = 8'd64;
      5: qubits = 8'd127;
      6: qubits = 8'd128;
      7: qubits = 8'd255;
      default: qubits = 8'($urandom_range(1, 255));
    endcase
    pick = $urandom_range(0, 3);
    case (pick)
      0: penalty = 8'd0;
      1: penalty = 8'd1;
      2: penalty = 8'd255;
      default: penalty = 8'($urandom_range(0, 255));
    endcase
    configure(qubits, 1'($urandom_range(0, 1)), penalty);
  endtask

  // Three blocks of random words, each under fresh register settings.
  task automatic random_blocks();
    repeat (3) begin
      settle();
      random_settings();
      repeat (80) send_random();
    end
  endtask

  initial begin
    int unsigned saved_idle;
    int unsigned waited;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles lightly, receiver heavily.
    sender_idle_pct   = 22;
    receiver_idle_pct = 74;

    // Reset settings: every operation once, widest indices, a CZ on one
    // qubit, the unused kind, and a new circuit restarting the count.
    send_word(make_word(KIND_GATE, 1'b0, 7'd0, 7'd127, 1'b1));
    send_word(make_word(KIND_GATE, 1'b0, 7'd127, 7'd0, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd0, 7'd127, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd5, 7'd5, 1'b1));
    send_word(make_word(KIND_LINK, 1'b1, 7'd127, 7'd127, 1'b1));
    send_word(make_word(KIND_LINK, 1'b0, 7'd0, 7'd0, 1'b0));
    send_word(make_word(KIND_UNUSED, 1'b1, 7'd127, 7'd127, 1'b1));
    send_word(make_word(KIND_NEW, 1'b1, 7'd127, 7'd127, 1'b1));
    send_word(make_word(KIND_GATE, 1'b0, 7'd0, 7'd0, 1'b0));

    // Four qubits, checking on, largest penalty: indices just out of range
    // on each side, then a linked and an unlinked pair.
    settle();
    configure(8'd4, 1'b1, 8'd255);
    send_word(make_word(KIND_GATE, 1'b0, 7'd4, 7'd0, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd0, 7'd4, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd4, 7'd0, 1'b0));
    send_word(make_word(KIND_LINK, 1'b0, 7'd4, 7'd1, 1'b1));
    send_word(make_word(KIND_LINK, 1'b0, 7'd1, 7'd4, 1'b1));
    send_word(make_word(KIND_LINK, 1'b0, 7'd2, 7'd1, 1'b1));
    send_word(make_word(KIND_GATE, 1'b1, 7'd2, 7'd1, 1'b0));
    send_word(make_word(KIND_LINK, 1'b0, 7'd1, 7'd2, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd1, 7'd2, 1'b0));
    send_word(make_word(KIND_LINK, 1'b0, 7'd3, 7'd3, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd3, 7'd3, 1'b0));

    // No qubits at all: every index is out of range.
    settle();
    configure(8'd0, 1'b0, 8'd0);
    send_word(make_word(KIND_GATE, 1'b0, 7'd0, 7'd0, 1'b0));
    send_word(make_word(KIND_LINK, 1'b0, 7'd0, 7'd0, 1'b1));
    send_word(make_word(KIND_NEW, 1'b0, 7'd0, 7'd0, 1'b0));
    send_word(make_word(KIND_UNUSED, 1'b0, 7'd0, 7'd0, 1'b0));

    // Count above the qubit total, zero penalty on an unlinked pair.
    settle();
    configure(8'd255, 1'b1, 8'd0);
    send_word(make_word(KIND_GATE, 1'b1, 7'd2, 7'd1, 1'b0));
    send_word(make_word(KIND_GATE, 1'b1, 7'd1, 7'd2, 1'b0));

    // Hold the result side off while words keep coming, so the block
    // fills up and stalls its input.
    settle();
    configure(8'd128, 1'b0, 8'd10);
    @(negedge clk) hold_request = 1'b1;
    @(posedge clk);
    saved_idle      = sender_idle_pct;
    sender_idle_pct = 0;
    repeat (30) send_random();
    sender_idle_pct = saved_idle;

    random_blocks();

    // Phase two: the other way round.
    sender_idle_pct   = 74;
    receiver_idle_pct = 22;
    random_blocks();

    // Phase three: no idling, words back to back from a fresh circuit.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    settle();
    configure(8'd128, 1'b1, 8'd255);
    send_word(make_word(KIND_NEW, 1'b0, 7'd0, 7'd0, 1'b0));
    random_blocks();

    // Drain, with a bound of its own, then leave a margin for stray words.
    in_valid <= 1'b0;
    for (waited = 0; waited < 20000 && tracker.outstanding() != 0; waited++)
      @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d result words never arrived", tracker.outstanding());
      tracker.failures++;
    end
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
